// File: hw/rtl/tbo_pkg.sv
// ----------------------------------------------------------------------------
// tbo_pkg
// widths and small helpers shared by the triangle / box overlap pipeline
// ----------------------------------------------------------------------------
package tbo_pkg;

  localparam int unsigned CoordW = 24;            // Q15.8 input coordinate
  localparam int unsigned SizeW  = 13;            // voxel edge in whole units
  localparam int unsigned FracW  = 8;
  localparam int unsigned SW     = SizeW + FracW; // doubled half extent
  localparam int unsigned VW     = 28;            // vertex relative to doubled center
  localparam int unsigned FW     = 27;            // triangle edge
  localparam int unsigned AbsW   = 28;            // sum of a pair of edge magnitudes
  localparam int unsigned PW     = VW + FW;       // one projection product
  localparam int unsigned RW     = SW + AbsW - 1; // projection radius, nine axes
  localparam int unsigned NMW    = 2 * FW;        // normal partial product
  localparam int unsigned NW     = NMW + 1;       // normal component
  localparam int unsigned NLoW   = 28;            // low split of a normal component
  localparam int unsigned NHiW   = NW - NLoW;
  localparam int unsigned NSumW  = NW + 2;        // sum of normal magnitudes
  localparam int unsigned NsLoW  = 29;
  localparam int unsigned NsHiW  = NSumW - NsLoW;
  localparam int unsigned DW     = 88;            // plane distance
  localparam int unsigned PRW    = 80;            // plane radius

  localparam logic [SizeW-1:0] SizeReset = SizeW'(1);

  typedef logic signed [VW-1:0] vtx_t [3];
  typedef logic signed [FW-1:0] edge_t [3];

  function automatic logic [FW-1:0] mag_f(logic signed [FW-1:0] a);
    mag_f = a[FW-1] ? FW'(-a) : FW'(a);
  endfunction

endpackage

// File: hw/rtl/triangle_box_overlap_test_top.sv
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_top
// separating-axis overlap test of a triangle against a cubic voxel
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 word
//  command   in         start / busy              corner_*, a_*, b_*, c_*
//  result    out        done strobe, one cycle    overlaps
//  config    in         apb psel/penable/pwrite   voxel_size at address 0
//
//  one word enters every cycle; busy stays low
//  the result pipe depth is set by the plane-test
//  multiplier stages (normal, split distance products, radius, compare)
//  reset clears the valid pipeline and sets voxel_size to 1
//  results are never held: the receiver takes each strobe as it comes
// ----------------------------------------------------------------------------
module triangle_box_overlap_test_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [23:0]            corner_x_i,
  input  logic signed [23:0]            corner_y_i,
  input  logic signed [23:0]            corner_z_i,
  input  logic signed [23:0]            a_x_i,
  input  logic signed [23:0]            a_y_i,
  input  logic signed [23:0]            a_z_i,
  input  logic signed [23:0]            b_x_i,
  input  logic signed [23:0]            b_y_i,
  input  logic signed [23:0]            b_z_i,
  input  logic signed [23:0]            c_x_i,
  input  logic signed [23:0]            c_y_i,
  input  logic signed [23:0]            c_z_i,
  output logic                          done_o,
  output logic                          overlaps_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tbo_pkg::*;

  localparam int unsigned Depth = 7;
  localparam logic [2:0] AddrSize = 3'd0;

  logic [SizeW-1:0] size_q;
  logic [Depth-1:0] vld_q;

  logic signed [CoordW-1:0] cor [3];
  logic signed [CoordW-1:0] pin [3][3];
  logic signed [VW-1:0]     v_d [3][3];
  logic signed [VW-1:0]     v_q [3][3];
  logic signed [FW-1:0]     f_q [3][3];
  logic [SW-1:0]            s_d, s_q;

  logic signed [PW-1:0]     m_q [3][3][2][2];
  logic [RW-1:0]            r_q [3][3];
  logic                     face_d, face_q;
  logic                     axis_d;
  logic                     sep3_q, sep4_q, sep5_q, sep6_q;
  logic                     plane_sep;
  logic                     ovl_q;

  edge_t f0, f1;
  vtx_t  v0;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == AddrSize) ? 32'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (psel && penable && pwrite && paddr == AddrSize) begin
      size_q <= pwdata[SizeW-1:0];
    end
  end

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Depth-2:0], start};
    end
  end

  // stage 1: doubled coordinates around the doubled box center
  assign cor = '{corner_x_i, corner_y_i, corner_z_i};
  assign pin = '{'{a_x_i, a_y_i, a_z_i}, '{b_x_i, b_y_i, b_z_i}, '{c_x_i, c_y_i, c_z_i}};
  assign s_d = {size_q, {FracW{1'b0}}};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        v_d[i][k] = (VW'(pin[i][k]) <<< 1) - (VW'(cor[k]) <<< 1)
                    - VW'($signed({1'b0, s_d}));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        v_q[i][k] <= v_d[i][k];
        f_q[i][k] <= (FW'(pin[(i+1)%3][k]) - FW'(pin[i][k])) <<< 1;
      end
    end
    s_q <= s_d;
  end

  // stage 2: projection products and radii for the edge axes, and the face axis test
  // the two endpoints of edge j project alike, so vertices j and j+2 suffice
  always_comb begin
    face_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if ((v_q[0][k] < -$signed({1'b0, s_q}) && v_q[1][k] < -$signed({1'b0, s_q})
           && v_q[2][k] < -$signed({1'b0, s_q}))
          || (v_q[0][k] > $signed({1'b0, s_q}) && v_q[1][k] > $signed({1'b0, s_q})
           && v_q[2][k] > $signed({1'b0, s_q}))) begin
        face_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        for (int t = 0; t < 2; t++) begin
          m_q[k][j][t][0] <= PW'(v_q[(j+2*t)%3][(k+2)%3]) * PW'(f_q[j][(k+1)%3]);
          m_q[k][j][t][1] <= PW'(v_q[(j+2*t)%3][(k+1)%3]) * PW'(f_q[j][(k+2)%3]);
        end
        r_q[k][j] <= RW'(s_q) * RW'(AbsW'(mag_f(f_q[j][(k+1)%3]))
                                    + AbsW'(mag_f(f_q[j][(k+2)%3])));
      end
    end
    face_q <= face_d;
  end

  // stage 3: edge axis compare, joined with the face axis result
  always_comb begin
    logic signed [PW:0] pa, pb, rr;
    axis_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        pa = (PW+1)'(m_q[k][j][0][0]) - (PW+1)'(m_q[k][j][0][1]);
        pb = (PW+1)'(m_q[k][j][1][0]) - (PW+1)'(m_q[k][j][1][1]);
        rr = $signed((PW+1)'(r_q[k][j]));
        if ((pa > rr && pb > rr) || (pa < -rr && pb < -rr)) begin
          axis_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sep3_q <= axis_d | face_q;
    sep4_q <= sep3_q;
    sep5_q <= sep4_q;
    sep6_q <= sep5_q;
  end

  assign f0 = f_q[0];
  assign f1 = f_q[1];
  assign v0 = v_q[0];

  tbo_plane u_plane (
    .clk_i (clk_i),
    .f0_i  (f0),
    .f1_i  (f1),
    .v0_i  (v0),
    .s_i   (s_q),
    .sep_o (plane_sep)
  );

  // stage 7: result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovl_q <= 1'b0;
    end else begin
      ovl_q <= vld_q[Depth-2] & ~sep6_q & ~plane_sep;
    end
  end

  assign done_o     = vld_q[Depth-1];
  assign overlaps_o = ovl_q;

  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Depth))
    else $error("result strobe without a matching start");

  a_no_flag_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !overlaps_o)
    else $error("overlap flag set outside a result cycle");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr == AddrSize) |=> size_q == $past(pwdata[SizeW-1:0]))
    else $error("voxel size write lost");

endmodule

// File: hw/rtl/tbo_plane.sv
// ----------------------------------------------------------------------------
// tbo_plane
// triangle plane test: normal, plane distance and radius over five stages
// ----------------------------------------------------------------------------
module tbo_plane (
  input  logic                           clk_i,
  input  tbo_pkg::edge_t                 f0_i,
  input  tbo_pkg::edge_t                 f1_i,
  input  tbo_pkg::vtx_t                  v0_i,
  input  logic [tbo_pkg::SW-1:0]         s_i,
  output logic                           sep_o
);
  import tbo_pkg::*;

  logic signed [NMW-1:0] nm_q [3][2];
  logic signed [NW-1:0]  n_q [3];
  logic signed [VW-1:0]  v0_2_q [3], v0_3_q [3];
  logic [SW-1:0]         s2_q, s3_q, s4_q;
  logic signed [NLoW+VW:0]     pl_q [3];
  logic signed [NHiW+VW-1:0]   ph_q [3];
  logic [NSumW-1:0]      nsum_q, nsum_d;
  logic signed [DW-1:0]  d_q, d_d;
  logic [SW+NsLoW-1:0]   rlo_q;
  logic [SW+NsHiW-1:0]   rhi_q;
  logic [DW-1:0]         dabs_q;
  logic [PRW-1:0]        r_q;

  // normal partial products
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      nm_q[k][0] <= NMW'(f0_i[(k+1)%3]) * NMW'(f1_i[(k+2)%3]);
      nm_q[k][1] <= NMW'(f0_i[(k+2)%3]) * NMW'(f1_i[(k+1)%3]);
      v0_2_q[k]  <= v0_i[k];
    end
    s2_q <= s_i;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      n_q[k]    <= NW'(nm_q[k][0]) - NW'(nm_q[k][1]);
      v0_3_q[k] <= v0_2_q[k];
    end
    s3_q <= s2_q;
  end

  always_comb begin
    nsum_d = '0;
    for (int k = 0; k < 3; k++) begin
      nsum_d = nsum_d + NSumW'(n_q[k][NW-1] ? NW'(-n_q[k]) : NW'(n_q[k]));
    end
  end

  // normal split in two halves so each multiplier operand stays near 28 bits
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pl_q[k] <= (NLoW+VW+1)'($signed({1'b0, n_q[k][NLoW-1:0]}))
                 * (NLoW+VW+1)'(v0_3_q[k]);
      ph_q[k] <= (NHiW+VW)'($signed(n_q[k][NW-1:NLoW])) * (NHiW+VW)'(v0_3_q[k]);
    end
    nsum_q <= nsum_d;
    s4_q   <= s3_q;
  end

  always_comb begin
    d_d = '0;
    for (int k = 0; k < 3; k++) begin
      d_d = d_d + (DW'(ph_q[k]) <<< NLoW) + DW'(pl_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    rlo_q <= (SW+NsLoW)'(s4_q) * (SW+NsLoW)'(nsum_q[NsLoW-1:0]);
    rhi_q <= (SW+NsHiW)'(s4_q) * (SW+NsHiW)'(nsum_q[NSumW-1:NsLoW]);
  end

  always_ff @(posedge clk_i) begin
    dabs_q <= d_q[DW-1] ? DW'(-d_q) : DW'(d_q);
    r_q    <= (PRW'(rhi_q) << NsLoW) + PRW'(rlo_q);
  end

  assign sep_o = dabs_q > DW'(r_q);

endmodule

// File: tb/triangle_box_overlap_test_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_top_test
// self-checking bench for the triangle / cubic voxel overlap pipeline: a
// queued command driver with random bursts and gaps, a result monitor, and
// an exact separating-axis predictor run across several voxel sizes
// ----------------------------------------------------------------------------
module triangle_box_overlap_test_top_test;
  import tbo_pkg::*;

  localparam logic [2:0] AddrVoxelSize = 3'd0;
  localparam int unsigned NumWords = 12;

  typedef struct packed {
    logic                        drain;  // hold off until the pipe is empty
    logic [NumWords-1:0][23:0]   w;      // corner xyz, then a, b, c xyz
  } tri_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [NumWords-1:0][23:0] drv_w = '0;
  logic done_o, overlaps_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tri_word_t pend_q[$];
  bit        overlap_q[$];
  logic [SizeW-1:0] voxel_size = SizeReset;
  int  errors = 0;
  int  gap_left = 0;
  int  burst_left = 4;

  triangle_box_overlap_test_top u_dut (
    .clk_i, .rst_ni, .start, .busy,
    .corner_x_i(drv_w[0]), .corner_y_i(drv_w[1]), .corner_z_i(drv_w[2]),
    .a_x_i(drv_w[3]), .a_y_i(drv_w[4]), .a_z_i(drv_w[5]),
    .b_x_i(drv_w[6]), .b_y_i(drv_w[7]), .b_z_i(drv_w[8]),
    .c_x_i(drv_w[9]), .c_y_i(drv_w[10]), .c_z_i(drv_w[11]),
    .done_o, .overlaps_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint iabs(longint a);
    return a < 0 ? -a : a;
  endfunction

  // exact separating-axis test, doubled coordinates around the box center
  function automatic bit tri_box_overlap(logic [NumWords-1:0][23:0] w,
                                         logic [SizeW-1:0] sz);
    longint s, lo, hi, r, p;
    longint v[3][3];
    longint f[3][3];
    longint ax[3];
    longint n[3];
    logic signed [127:0] d, pr, nw, vw;
    longint cn, cv;
    s = longint'(sz) << FracW;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        cv = $signed(w[3 + 3 * i + k]);
        cn = $signed(w[k]);
        v[i][k] = 2 * cv - 2 * cn - s;
      end
    for (int k = 0; k < 3; k++) begin
      f[0][k] = v[1][k] - v[0][k];
      f[1][k] = v[2][k] - v[1][k];
      f[2][k] = v[0][k] - v[2][k];
    end
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++) begin
        if (k == 0) begin
          ax[0] = 0; ax[1] = -f[j][2]; ax[2] = f[j][1];
        end else if (k == 1) begin
          ax[0] = f[j][2]; ax[1] = 0; ax[2] = -f[j][0];
        end else begin
          ax[0] = -f[j][1]; ax[1] = f[j][0]; ax[2] = 0;
        end
        for (int i = 0; i < 3; i++) begin
          p = v[i][0] * ax[0] + v[i][1] * ax[1] + v[i][2] * ax[2];
          if (i == 0 || p < lo) lo = (i == 0) ? p : p;
          if (i == 0) hi = p;
          else if (p > hi) hi = p;
        end
        r = s * (iabs(ax[0]) + iabs(ax[1]) + iabs(ax[2]));
        if (lo > r || hi < -r) return 1'b0;
      end
    for (int k = 0; k < 3; k++) begin
      lo = v[0][k]; hi = v[0][k];
      for (int i = 1; i < 3; i++) begin
        if (v[i][k] < lo) lo = v[i][k];
        if (v[i][k] > hi) hi = v[i][k];
      end
      if (hi < -s || lo > s) return 1'b0;
    end
    n[0] = f[0][1] * f[1][2] - f[0][2] * f[1][1];
    n[1] = f[0][2] * f[1][0] - f[0][0] * f[1][2];
    n[2] = f[0][0] * f[1][1] - f[0][1] * f[1][0];
    d = '0;
    pr = '0;
    for (int k = 0; k < 3; k++) begin
      nw = n[k];
      vw = v[0][k];
      d = d + nw * vw;
      nw = iabs(n[k]);
      pr = pr + nw;
    end
    vw = s;
    pr = pr * vw;
    if (d < 0) d = -d;
    return !(d > pr);
  endfunction

  // driver: takes the accepted word, then launches the next one
  always @(posedge clk_i or negedge rst_ni) begin
    tri_word_t nxt;
    logic launch;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        overlap_q.insert(overlap_q.size(), tri_box_overlap(drv_w, voxel_size));
      launch = start && busy;
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0 &&
                     !(pend_q[0].drain && (overlap_q.size() > 0 || start))) begin
          nxt = pend_q.pop_front();
          drv_w <= nxt.w;
          launch = 1'b1;
          if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
      end
      start <= launch;
    end
  end

  // monitor: every strobe is taken as it comes
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && done_o) begin
      if (overlap_q.size() == 0) begin
        $display("%0t: overlaps expected none actual %0b", $time, overlaps_o);
        errors++;
      end else begin
        want = overlap_q.pop_front();
        if (overlaps_o !== want) begin
          $display("%0t: overlaps expected %0b actual %0b", $time, want, overlaps_o);
          errors++;
        end
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrVoxelSize) voxel_size = data[SizeW-1:0];
  endtask

  task automatic wait_idle();
    while (pend_q.size() > 0 || overlap_q.size() > 0 || start) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic tri_word_t same_word(logic [23:0] cn, logic [23:0] pt);
    tri_word_t t;
    t.drain = 1'b0;
    for (int j = 0; j < 3; j++) t.w[j] = cn;
    for (int j = 3; j < NumWords; j++) t.w[j] = pt;
    return t;
  endfunction

  task automatic add_directed();
    tri_word_t t;
    pend_q.insert(pend_q.size(), same_word(24'h800000, 24'h800000));
    pend_q.insert(pend_q.size(), same_word(24'h7fffff, 24'h7fffff));
    pend_q.insert(pend_q.size(), same_word(24'h800000, 24'h7fffff));
    pend_q.insert(pend_q.size(), same_word(24'h7fffff, 24'h800000));
    // point triangle on the min corner touches, one lsb below does not
    pend_q.insert(pend_q.size(), same_word(24'h000100, 24'h000100));
    pend_q.insert(pend_q.size(), same_word(24'h000100, 24'h0000ff));
    // point on the far corner of a unit box
    pend_q.insert(pend_q.size(), same_word(24'h000000, 24'h000100));
    pend_q.insert(pend_q.size(), same_word(24'h000000, 24'h000101));
    // segment crossing the box, degenerate normal
    t = same_word(24'h000000, 24'h000080);
    t.w[3] = 24'hff0000; t.w[6] = 24'h010000; t.w[9] = 24'h010000;
    pend_q.insert(pend_q.size(), t);
    // large triangle in the plane z = 0.5 passing through the box
    t = same_word(24'h000000, 24'h000080);
    t.w[3] = 24'hf00000; t.w[4] = 24'hf00000;
    t.w[6] = 24'h100000; t.w[7] = 24'hf00000;
    t.w[9] = 24'h000000; t.w[10] = 24'h100000;
    pend_q.insert(pend_q.size(), t);
    // same triangle lifted just off the top face, then touching it
    t.w[5] = 24'h000101; t.w[8] = 24'h000101; t.w[11] = 24'h000101;
    pend_q.insert(pend_q.size(), t);
    t.w[5] = 24'h000100; t.w[8] = 24'h000100; t.w[11] = 24'h000100;
    t.drain = 1'b1;
    pend_q.insert(pend_q.size(), t);
    // diagonal triangle near an edge, decided by an edge axis
    t = same_word(24'h000000, 24'h000000);
    t.w[3] = 24'h000300; t.w[4] = 24'hfffe00; t.w[5] = 24'h000080;
    t.w[6] = 24'hfffe00; t.w[7] = 24'h000300; t.w[8] = 24'h000080;
    t.w[9] = 24'h000300; t.w[10] = 24'h000300; t.w[11] = 24'h000080;
    pend_q.insert(pend_q.size(), t);
  endtask

  task automatic add_random(int count, logic [SizeW-1:0] sz);
    tri_word_t t;
    int span;
    span = int'(sz) * 512 + 64;
    for (int n = 0; n < count; n++) begin
      t.drain = ($urandom_range(0, 60) == 0);
      for (int j = 0; j < 3; j++) t.w[j] = $urandom;
      if ($urandom_range(0, 4) == 0) begin
        for (int j = 3; j < NumWords; j++) t.w[j] = $urandom;
      end else begin
        for (int j = 3; j < NumWords; j++)
          t.w[j] = t.w[j % 3] + 24'($urandom_range(0, 2 * span) - span / 2);
      end
      pend_q.insert(pend_q.size(), t);
    end
  endtask

  initial begin
    logic [SizeW-1:0] sizes[6];
    sizes = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd37, 13'd2};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_directed();
    add_random(60, voxel_size);
    wait_idle();
    for (int ph = 0; ph < 6; ph++) begin
      apb_write(AddrVoxelSize, {19'h0, sizes[ph]});
      if (ph == 0) add_directed();
      add_random(70, voxel_size);
      wait_idle();
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tbo_pkg.sv
hw/rtl/tbo_plane.sv
hw/rtl/triangle_box_overlap_test_top.sv
tb/triangle_box_overlap_test_top_test.sv
